[hw/rtl/idq_pkg.sv]
`default_nettype none

package idq_pkg;

  // storage geometry
  localparam int DEPTH    = 16;
  localparam int VALUE_W  = 64;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int FUNC_W   = 3;
  localparam int ITEM_W   = 64;
  localparam int POS_W    = 4;
  localparam int RESULT_W = 64;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP_TAIL  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ITEM_W-1:0] item_value;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [RESULT_W-1:0] result_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_DEL,
    S_INS,
    S_PUT,
    S_DONE
  } state_t;

  // logical position from head to ring address
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  lidx);
    logic [ADDR_W:0] sum;
    sum = (ADDR_W+1)'(head) + (ADDR_W+1)'(lidx);
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/indexed_deque_top.sv]
// indexed deque: bounded ordered store of DEPTH values, head at position 0
//
// request channel (req_valid / req_stall, payload req): one beat names an
// operation (push or pop at either end, read, delete or insert at a position)
// with a value and a position. response channel (rsp_valid / rsp_stall,
// payload rsp): exactly one beat per request with value, status, occupancy.
//
// values sit in a ring buffer in one synchronous ram (one write and one read
// port, registered read data); a head pointer makes end operations cheap.
// push writes the ram on acceptance, pop and read wait for a ram read, delete
// shifts the values behind position p toward the head and insert those from p
// on toward the tail; the ram port moves one value per cycle for the shifts.
// one request is worked on at a time; req_stall is high while it is.
// the response register lets a new request start while a response waits,
// but a finished request holds until rsp_stall drops.
// reset empties the store at once and drops any waiting response beat;
// ram contents are not cleared and are never read before written.
`default_nettype none

module indexed_deque_top
  import idq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   head;
  logic [FUNC_W-1:0]   op;
  logic [VALUE_W-1:0]  val;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    idx;
  logic [RESULT_W-1:0] res_val;
  logic [STATUS_W-1:0] res_st;

  // ring storage
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic [VALUE_W-1:0] wdata;
  logic               we;

  logic                is_full;
  logic                is_empty;
  logic                pos_miss;
  logic [STATUS_W-1:0] req_status;
  logic [ADDR_W-1:0]   head_inc;
  logic [ADDR_W-1:0]   head_dec;
  logic [VALUE_W-1:0]  in_val;
  logic                rsp_load;

  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign pos_miss = (32'(req.position) >= 32'(count));
  assign in_val   = req.item_value[VALUE_W-1:0];
  assign head_inc = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + ADDR_W'(1);
  assign head_dec = (head == '0) ? ADDR_W'(DEPTH - 1) : head - ADDR_W'(1);

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // status of an incoming request
  always_comb begin
    case (req.func)
      FN_PUSH_TAIL, FN_PUSH_HEAD: req_status = is_full ? STAT_FULL : STAT_OK;
      FN_POP_TAIL, FN_POP_HEAD:   req_status = is_empty ? STAT_MISS : STAT_OK;
      FN_READ, FN_DELETE:         req_status = pos_miss ? STAT_MISS : STAT_OK;
      FN_INSERT: begin
        if (is_full) begin
          req_status = STAT_FULL;
        end else if (pos_miss) begin
          req_status = STAT_MISS;
        end else begin
          req_status = STAT_OK;
        end
      end
      default: req_status = STAT_MISS;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_status != STAT_OK) begin
            state_next = S_DONE;
          end else begin
            case (req.func)
              FN_POP_TAIL, FN_POP_HEAD, FN_READ, FN_DELETE: state_next = S_RD;
              FN_INSERT: state_next = S_INS;
              default:   state_next = S_DONE;
            endcase
          end
        end
      end
      S_RD: begin
        if ((op == FN_DELETE) && ((CNT_W+1)'(pos) + (CNT_W+1)'(1) < (CNT_W+1)'(count))) begin
          state_next = S_DEL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DEL: begin
        if ((CNT_W+1)'(idx) + (CNT_W+1)'(2) < (CNT_W+1)'(count)) begin
          state_next = S_DEL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_INS: begin
        if (idx - CNT_W'(1) > pos) begin
          state_next = S_INS;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: state_next = S_DONE;
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    case (state)
      S_IDLE: begin
        case (req.func)
          FN_POP_TAIL: raddr = phys_addr(head, count - CNT_W'(1));
          FN_POP_HEAD: raddr = head;
          FN_READ, FN_DELETE: raddr = phys_addr(head, CNT_W'(req.position));
          FN_INSERT: raddr = phys_addr(head, count - CNT_W'(1));
          default: raddr = '0;
        endcase
        if (req_valid && (req_status == STAT_OK)) begin
          case (req.func)
            FN_PUSH_TAIL: begin
              we    = 1'b1;
              waddr = phys_addr(head, count);
              wdata = in_val;
            end
            FN_PUSH_HEAD: begin
              we    = 1'b1;
              waddr = head_dec;
              wdata = in_val;
            end
            default: we = 1'b0;
          endcase
        end
      end
      S_RD: raddr = phys_addr(head, pos + CNT_W'(1));
      S_DEL: begin
        // move the value behind idx one step toward the head
        we    = 1'b1;
        waddr = phys_addr(head, idx);
        raddr = phys_addr(head, idx + CNT_W'(2));
      end
      S_INS: begin
        // move the value before idx one step toward the tail
        we    = 1'b1;
        waddr = phys_addr(head, idx);
        raddr = phys_addr(head, idx - CNT_W'(2));
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = phys_addr(head, pos);
        wdata = val;
      end
      default: we = 1'b0;
    endcase
  end

  // ring ram
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.func;
            val     <= in_val;
            pos     <= CNT_W'(req.position);
            res_val <= '0;
            res_st  <= req_status;
            idx     <= count;
            if (req_status == STAT_OK) begin
              case (req.func)
                FN_PUSH_TAIL: count <= count + CNT_W'(1);
                FN_PUSH_HEAD: begin
                  head  <= head_dec;
                  count <= count + CNT_W'(1);
                end
                FN_POP_TAIL: count <= count - CNT_W'(1);
                FN_POP_HEAD: begin
                  head  <= head_inc;
                  count <= count - CNT_W'(1);
                end
                default: count <= count;
              endcase
            end
          end
        end
        S_RD: begin
          res_val <= RESULT_W'(rdata);
          idx     <= pos;
          if ((op == FN_DELETE) &&
              !((CNT_W+1)'(pos) + (CNT_W+1)'(1) < (CNT_W+1)'(count))) begin
            count <= count - CNT_W'(1);
          end
        end
        S_DEL: begin
          idx <= idx + CNT_W'(1);
          if (!((CNT_W+1)'(idx) + (CNT_W+1)'(2) < (CNT_W+1)'(count))) begin
            count <= count - CNT_W'(1);
          end
        end
        S_INS: idx <= idx - CNT_W'(1);
        S_PUT: count <= count + CNT_W'(1);
        default: idx <= idx;
      endcase

      // response register
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response beat payload
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.result_value <= res_val;
      rsp.status       <= res_st;
      rsp.occupancy    <= OCC_W'(count);
    end
  end

endmodule

`default_nettype wire
